// ===== rtl/core/smt_pkg.sv =====
// Shared types and codes for the set membership table.
// Used by the slot cell, the top level and the checker; depends on nothing.
package smt_pkg;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_DEL   = 2'd1,
    OP_QUERY = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_DUP    = 2'd1,
    ST_ABSENT = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef struct packed {
    logic add_en;
    logic del_en;
    logic clr_all;
  } cell_ctl_t;

endpackage

// ===== rtl/core/set_membership_table_top.sv =====
// Top level of the set membership table: a row of slot cells plus control.
// Depends on smt_pkg and smt_cell.
//
// Usage: drive in_mode and in_value with start high; the command is taken
// at a rising edge where start is high and busy is low. Each command gives
// exactly one result on out_present, out_status and out_count, marked by
// out_strobe for one cycle.
// The accept is registered into busy, and busy is registered into the result
// strobe; the result fields are registered while busy is high.
// No command is accepted while busy is high. In the accept cycle every cell
// compares its slot against in_value and the free-slot priority signal
// ripples along the row; in the following cycle (busy high) the matching
// or lowest free cell is updated and the result is registered.
// The next command may be accepted while the previous result is shown.
// Reset clears every valid bit and the element count; slot
// values are not cleared and are never compared while invalid.
// The receiver cannot stall: each result is valid for exactly one cycle.
module set_membership_table_top #(
  parameter int CAPACITY   = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic signed [31:0] in_value,
  output logic        out_strobe,
  output logic        out_present,
  output logic [1:0]  out_status,
  output logic [4:0]  out_count
);

  localparam int CW    = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CW-1:0]      value_r;
  smt_pkg::op_t       op_r;
  logic               phase_b_r;
  logic               full_r;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  logic               out_strobe_r;
  logic               out_present_r;
  smt_pkg::status_t   out_status_r;
  logic [4:0]         out_count_r;
  logic               accept;
  logic               hit;
  logic [CAPACITY:0]  free_chain;
  logic [CAPACITY-1:0] match;
  smt_pkg::cell_ctl_t ctl;
  smt_pkg::status_t   status_nxt;
  logic [CNT_W+4:0]   count_ext;

  assign accept        = start & ~phase_b_r;
  assign busy          = phase_b_r;
  assign free_chain[0] = 1'b0;
  assign hit           = |match;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      smt_cell #(.W(CW)) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ld        (accept),
        .cmp_value (in_value[CW-1:0]),
        .wr_value  (value_r),
        .free_in   (free_chain[g]),
        .free_out  (free_chain[g+1]),
        .ctl       (ctl),
        .match_o   (match[g])
      );
    end
  endgenerate

  always_comb begin
    ctl        = '0;
    status_nxt = smt_pkg::ST_DONE;
    count_nxt  = count_r;
    case (op_r)
      smt_pkg::OP_ADD: begin
        if (hit) begin
          status_nxt = smt_pkg::ST_DUP;
        end else if (full_r) begin
          status_nxt = smt_pkg::ST_FULL;
        end else begin
          ctl.add_en = phase_b_r;
          count_nxt  = count_r + CNT_W'(1);
        end
      end
      smt_pkg::OP_DEL: begin
        if (hit) begin
          ctl.del_en = phase_b_r;
          if (count_r != '0) begin
            count_nxt = count_r - CNT_W'(1);
          end
        end else begin
          status_nxt = smt_pkg::ST_ABSENT;
        end
      end
      smt_pkg::OP_QUERY: begin
      end
      smt_pkg::OP_CLEAR: begin
        ctl.clr_all = phase_b_r;
        count_nxt   = '0;
      end
      default: begin
      end
    endcase
  end

  assign count_ext = (CNT_W + 5)'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_b_r    <= 1'b0;
      out_strobe_r <= 1'b0;
      count_r      <= '0;
    end else begin
      phase_b_r    <= accept;
      out_strobe_r <= phase_b_r;
      if (phase_b_r) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= smt_pkg::op_t'(in_mode);
      value_r <= in_value[CW-1:0];
      full_r  <= ~free_chain[CAPACITY] | (32'(count_r) >= 32'(CAPACITY));
    end
    if (phase_b_r) begin
      out_present_r <= hit & (op_r != smt_pkg::OP_CLEAR);
      out_status_r  <= status_nxt;
      out_count_r   <= count_ext[4:0];
    end
  end

  assign out_strobe  = out_strobe_r;
  assign out_present = out_present_r;
  assign out_status  = out_status_r;
  assign out_count   = out_count_r;

endmodule

// ===== rtl/core/smt_cell.sv =====
// One slot of the set: stored value, valid bit, match and free-slot flags.
// Passes the free-slot priority signal to its neighbor; uses smt_pkg.
module smt_cell #(
  parameter int W = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 ld,
  input  logic [W-1:0]         cmp_value,
  input  logic [W-1:0]         wr_value,
  input  logic                 free_in,
  output logic                 free_out,
  input  smt_pkg::cell_ctl_t   ctl,
  output logic                 match_o
);

  logic [W-1:0] value_r;
  logic         valid_r;
  logic         match_r;
  logic         pick_r;

  assign free_out = free_in | ~valid_r;
  assign match_o  = match_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.clr_all) begin
      valid_r <= 1'b0;
    end else if (ctl.del_en && match_r) begin
      valid_r <= 1'b0;
    end else if (ctl.add_en && pick_r) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.add_en && pick_r && !ctl.clr_all) begin
      value_r <= wr_value;
    end
    if (ld) begin
      match_r <= valid_r & (value_r == cmp_value);
      pick_r  <= ~valid_r & ~free_in;
    end
  end

endmodule

// ===== rtl/core/smt_checker.sv =====
// Port-level checker for the set membership table, bound to the top level.
// Depends on smt_pkg and set_membership_table_top.
module smt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_strobe,
  input logic       out_present,
  input logic [1:0] out_status
);

  a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted transfer did not raise busy");

  a_busy_then_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_strobe && !busy) else $error("result strobe missing after busy");

  a_strobe_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy)) else $error("result strobe without a command");

  a_dup_present: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_status == smt_pkg::ST_DUP) |-> out_present)
    else $error("duplicate status without present");

  a_absent_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_status == smt_pkg::ST_ABSENT || out_status == smt_pkg::ST_FULL)
    |-> !out_present) else $error("absent or full status with present set");

endmodule

bind set_membership_table_top smt_checker u_smt_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .out_strobe  (out_strobe),
  .out_present (out_present),
  .out_status  (out_status)
);
